@@ sv/assert_macros.svh @@
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define CND_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/cnd_pkg.sv @@
package cnd_pkg;

  localparam int unsigned CHAN_W           = 6;
  localparam int unsigned LAYER_IDX_W      = 8;
  localparam int unsigned DEPTH_W          = 9;
  localparam int unsigned NUM_CHANNELS_DEF = 64;
  localparam int unsigned MAX_LAYERS_DEF   = 256;

  // Channel table update issued by the assignment stage
  typedef struct packed {
    logic              en;
    logic              clear;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] hi;
  } cnd_wr_t;

endpackage

@@ sv/cnd_if.sv @@
interface cnd_cmp_if;
  import cnd_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_network;
  logic [CHAN_W-1:0] lo_channel;
  logic [CHAN_W-1:0] hi_channel;

  modport source (output valid, start_network, lo_channel, hi_channel, input ready);
  modport sink   (input valid, start_network, lo_channel, hi_channel, output ready);
endinterface

interface cnd_res_if;
  import cnd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LAYER_IDX_W-1:0] layer_index;
  logic [DEPTH_W-1:0]     network_depth;
  logic                   overflow;

  modport source (output valid, layer_index, network_depth, overflow, input ready);
  modport sink   (input valid, layer_index, network_depth, overflow, output ready);
endinterface

@@ sv/cnd_chan_store.sv @@
module cnd_chan_store #(
  parameter int unsigned NUM_CHANNELS = cnd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_LAYERS   = cnd_pkg::MAX_LAYERS_DEF,
  localparam int unsigned LW          = $clog2(MAX_LAYERS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [cnd_pkg::CHAN_W-1:0]  rd_lo_i,
  input  logic [cnd_pkg::CHAN_W-1:0]  rd_hi_i,
  input  logic [cnd_pkg::CHAN_W-1:0]  cur_lo_i,
  input  logic [cnd_pkg::CHAN_W-1:0]  cur_hi_i,
  input  cnd_pkg::cnd_wr_t            wr_i,
  input  logic [LW-1:0]               wr_val_i,
  output logic [LW-1:0]               lo_layer_o,
  output logic [LW-1:0]               hi_layer_o
);
  import cnd_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CHANNELS);

  // Two banks, one per write port; lvt_q marks which bank holds the latest value
  logic [LW-1:0] bank0_q [NUM_CHANNELS];
  logic [LW-1:0] bank1_q [NUM_CHANNELS];
  logic [LW-1:0] b0_lo_q, b0_hi_q, b1_lo_q, b1_hi_q;

  logic [NUM_CHANNELS-1:0] valid_q, valid_d;
  logic [NUM_CHANNELS-1:0] lvt_q, lvt_d;

  // Write that landed on the same edge as the read: bypass the stale read data
  logic              fwd_en_q;
  logic [CHAN_W-1:0] fwd_lo_q, fwd_hi_q;
  logic [LW-1:0]     fwd_val_q;

  logic [CW-1:0] lo_idx, hi_idx;
  logic          lo_hit, hi_hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      bank0_q[wr_i.lo[CW-1:0]] <= wr_val_i;
      bank1_q[wr_i.hi[CW-1:0]] <= wr_val_i;
    end
    if (rd_en_i) begin
      b0_lo_q <= bank0_q[rd_lo_i[CW-1:0]];
      b0_hi_q <= bank0_q[rd_hi_i[CW-1:0]];
      b1_lo_q <= bank1_q[rd_lo_i[CW-1:0]];
      b1_hi_q <= bank1_q[rd_hi_i[CW-1:0]];
    end
  end

  always_comb begin
    valid_d = wr_i.clear ? '0 : valid_q;
    lvt_d   = lvt_q;
    if (wr_i.en) begin
      valid_d[wr_i.lo[CW-1:0]] = 1'b1;
      valid_d[wr_i.hi[CW-1:0]] = 1'b1;
      lvt_d[wr_i.lo[CW-1:0]]   = 1'b0;
      lvt_d[wr_i.hi[CW-1:0]]   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      lvt_q    <= '0;
      fwd_en_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lvt_q   <= lvt_d;
      if (rd_en_i) begin
        fwd_en_q <= wr_i.en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_lo_q  <= wr_i.lo;
      fwd_hi_q  <= wr_i.hi;
      fwd_val_q <= wr_val_i;
    end
  end

  assign lo_idx = cur_lo_i[CW-1:0];
  assign hi_idx = cur_hi_i[CW-1:0];
  assign lo_hit = fwd_en_q && (cur_lo_i == fwd_lo_q || cur_lo_i == fwd_hi_q);
  assign hi_hit = fwd_en_q && (cur_hi_i == fwd_lo_q || cur_hi_i == fwd_hi_q);

  always_comb begin
    if (lo_hit) begin
      lo_layer_o = fwd_val_q;
    end else if (valid_q[lo_idx]) begin
      lo_layer_o = lvt_q[lo_idx] ? b1_lo_q : b0_lo_q;
    end else begin
      lo_layer_o = '0;
    end
  end

  always_comb begin
    if (hi_hit) begin
      hi_layer_o = fwd_val_q;
    end else if (valid_q[hi_idx]) begin
      hi_layer_o = lvt_q[hi_idx] ? b1_hi_q : b0_hi_q;
    end else begin
      hi_layer_o = '0;
    end
  end

endmodule

@@ sv/cnd_assign.sv @@
`include "assert_macros.svh"

module cnd_assign #(
  parameter int unsigned NUM_CHANNELS = cnd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_LAYERS   = cnd_pkg::MAX_LAYERS_DEF,
  localparam int unsigned LW          = $clog2(MAX_LAYERS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_start_i,
  input  logic [cnd_pkg::CHAN_W-1:0]      in_lo_i,
  input  logic [cnd_pkg::CHAN_W-1:0]      in_hi_i,
  output logic                            accept_o,
  output logic [cnd_pkg::CHAN_W-1:0]      cur_lo_o,
  output logic [cnd_pkg::CHAN_W-1:0]      cur_hi_o,
  input  logic [LW-1:0]                   lo_layer_i,
  input  logic [LW-1:0]                   hi_layer_i,
  output cnd_pkg::cnd_wr_t                wr_o,
  output logic [LW-1:0]                   wr_val_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cnd_pkg::LAYER_IDX_W-1:0] out_layer_o,
  output logic [cnd_pkg::DEPTH_W-1:0]     out_depth_o,
  output logic                            out_overflow_o
);
  import cnd_pkg::*;

  localparam logic [CHAN_W:0] NCH  = (CHAN_W + 1)'(NUM_CHANNELS);
  localparam logic [LW-1:0]   LMAX = LW'(MAX_LAYERS);

  logic              s1_valid_q, s1_start_q;
  logic [CHAN_W-1:0] s1_lo_q, s1_hi_q;
  logic              s1_adv;

  logic [LW-1:0] depth_q, depth_d, base_depth;
  logic [LW-1:0] la, lb, layer, layer_next;
  logic          in_range, ovf, do_wr;

  logic                   out_valid_q;
  logic [LAYER_IDX_W-1:0] out_layer_q;
  logic [DEPTH_W-1:0]     out_depth_q;
  logic                   out_ovf_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept_o   = in_valid_i && in_ready_o;
  assign cur_lo_o   = s1_lo_q;
  assign cur_hi_o   = s1_hi_q;

  // Start of a new network: treat every channel and the depth as cleared
  always_comb begin
    in_range   = ({1'b0, s1_lo_q} < NCH) && ({1'b0, s1_hi_q} < NCH);
    la         = s1_start_q ? '0 : lo_layer_i;
    lb         = s1_start_q ? '0 : hi_layer_i;
    base_depth = s1_start_q ? '0 : depth_q;
    layer      = (la > lb) ? la : lb;
    ovf        = in_range && (layer >= LMAX);
    do_wr      = in_range && !ovf;
    layer_next = layer + LW'(1);
    depth_d    = (do_wr && (layer_next > base_depth)) ? layer_next : base_depth;
  end

  assign wr_o.en    = s1_adv && do_wr;
  assign wr_o.clear = s1_adv && s1_start_q;
  assign wr_o.lo    = s1_lo_q;
  assign wr_o.hi    = s1_hi_q;
  assign wr_val_o   = layer_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
    end else begin
      if (accept_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        depth_q     <= depth_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_start_q <= in_start_i;
      s1_lo_q    <= in_lo_i;
      s1_hi_q    <= in_hi_i;
    end
    if (s1_adv) begin
      out_layer_q <= do_wr ? LAYER_IDX_W'(layer) : '0;
      out_depth_q <= DEPTH_W'(depth_d);
      out_ovf_q   <= ovf;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_layer_o    = out_layer_q;
  assign out_depth_o    = out_depth_q;
  assign out_overflow_o = out_ovf_q;

  `CND_ASSERT(a_depth_grows, s1_adv && !s1_start_q |=> depth_q >= $past(depth_q), "depth shrank without a new network")
  `CND_NEVER(a_depth_bound, depth_q > LMAX, "depth beyond layer limit")
  `CND_ASSERT(a_stall_cause, !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i, "input stalled without a full pipe")
  `CND_ASSERT(a_ovf_no_layer, out_valid_q && out_ovf_q |-> out_layer_q == '0, "overflow result carries a layer")

endmodule

@@ sv/comparator_network_depth_top.sv @@
// Two-stage pipe: stage 1 holds the accepted comparator, the output register its result.
// Throughput: one comparator per cycle while results are taken; the channel read, max and
// write-back close in stage 1, with a bypass of the write that lands on the same edge as the next read.
// Reset: asynchronous, active low; clears pipe valids, network depth and per-channel valid
// bits at once, so the channel table reads as all zero with no clearing pass.
module comparator_network_depth_top #(
  parameter int unsigned NUM_CHANNELS = cnd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_LAYERS   = cnd_pkg::MAX_LAYERS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cnd_cmp_if.sink        cmp_i,
  cnd_res_if.source      res_o
);
  import cnd_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LAYERS + 1);

  logic              accept;
  logic [CHAN_W-1:0] cur_lo, cur_hi;
  logic [LW-1:0]     lo_layer, hi_layer, wr_val;
  cnd_wr_t           wr;

  cnd_chan_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_LAYERS   (MAX_LAYERS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_lo_i    (cmp_i.lo_channel),
    .rd_hi_i    (cmp_i.hi_channel),
    .cur_lo_i   (cur_lo),
    .cur_hi_i   (cur_hi),
    .wr_i       (wr),
    .wr_val_i   (wr_val),
    .lo_layer_o (lo_layer),
    .hi_layer_o (hi_layer)
  );

  cnd_assign #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_LAYERS   (MAX_LAYERS)
  ) u_assign (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (cmp_i.valid),
    .in_ready_o     (cmp_i.ready),
    .in_start_i     (cmp_i.start_network),
    .in_lo_i        (cmp_i.lo_channel),
    .in_hi_i        (cmp_i.hi_channel),
    .accept_o       (accept),
    .cur_lo_o       (cur_lo),
    .cur_hi_o       (cur_hi),
    .lo_layer_i     (lo_layer),
    .hi_layer_i     (hi_layer),
    .wr_o           (wr),
    .wr_val_o       (wr_val),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .out_layer_o    (res_o.layer_index),
    .out_depth_o    (res_o.network_depth),
    .out_overflow_o (res_o.overflow)
  );

endmodule
